FILE: design/lcdc_pkg.sv
// package for the segment lcd controller with display memory
// holds request/result structs, state enum, command struct and font rom
// no dependencies
package lcdc_pkg;

  localparam int unsigned MemDepthDefault = 128;

  localparam logic [1:0] ActInstr = 2'd0;
  localparam logic [1:0] ActData  = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;

  localparam logic [7:0] ModeReset = 8'h64;
  localparam logic [7:0] ModeRight = 8'h72;
  localparam logic [7:0] ModeLeft  = 8'h71;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] value;
    logic [6:0] read_address;
  } lcdc_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] pointer_now;
    logic [7:0] mode_now;
  } lcdc_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StClear,
    StExec,
    StChar,
    StRead,
    StOut
  } lcdc_state_e;

  typedef enum logic [1:0] {
    OpNone,
    OpExec,
    OpChar,
    OpRead
  } lcdc_op_e;

  typedef struct packed {
    lcdc_op_e   op;
    logic       load_req;
    logic       clr;
    logic [2:0] col;
    logic       load_out;
  } lcdc_cmd_t;

  typedef struct packed {
    logic is_char;
    logic is_read;
    logic clr_last;
  } lcdc_sts_t;

  function automatic logic [6:0] step_ptr(logic [6:0] p, logic [1:0] s);
    logic [6:0] r;
    r = p;
    if (s == 2'd0) r = p + 7'd1;
    else if (s == 2'd1) r = p - 7'd1;
    return r;
  endfunction

  function automatic logic [7:0] glyph_lo(logic [8:0] i);
    logic [7:0] r;
    case (i)
      9'd7: r=8'h4F; 9'd11: r=8'h07; 9'd13: r=8'h07;
      9'd15: r=8'h14; 9'd16: r=8'h7F; 9'd17: r=8'h14; 9'd18: r=8'h7F; 9'd19: r=8'h14;
      9'd20: r=8'h2C; 9'd21: r=8'h2A; 9'd22: r=8'h7F; 9'd23: r=8'h2A; 9'd24: r=8'h12;
      9'd25: r=8'h23; 9'd26: r=8'h13; 9'd27: r=8'h08; 9'd28: r=8'h64; 9'd29: r=8'h62;
      9'd30: r=8'h36; 9'd31: r=8'h49; 9'd32: r=8'h55; 9'd33: r=8'h22; 9'd34: r=8'h50;
      9'd36: r=8'h05; 9'd37: r=8'h03;
      9'd42: r=8'h1C; 9'd43: r=8'h22; 9'd44: r=8'h41;
      9'd45: r=8'h41; 9'd46: r=8'h22; 9'd47: r=8'h1C;
      9'd50: r=8'h14; 9'd51: r=8'h08; 9'd52: r=8'h3E; 9'd53: r=8'h08; 9'd54: r=8'h14;
      9'd55: r=8'h08; 9'd56: r=8'h08; 9'd57: r=8'h3E; 9'd58: r=8'h08; 9'd59: r=8'h08;
      9'd60: r=8'h50; 9'd61: r=8'h30;
      9'd65: r=8'h08; 9'd66: r=8'h08; 9'd67: r=8'h08; 9'd68: r=8'h08; 9'd69: r=8'h08;
      9'd71: r=8'h60; 9'd72: r=8'h60;
      9'd75: r=8'h20; 9'd76: r=8'h10; 9'd77: r=8'h08; 9'd78: r=8'h04; 9'd79: r=8'h02;
      9'd80: r=8'h3E; 9'd81: r=8'h51; 9'd82: r=8'h49; 9'd83: r=8'h45; 9'd84: r=8'h3E;
      9'd86: r=8'h42; 9'd87: r=8'h7F; 9'd88: r=8'h40;
      9'd90: r=8'h42; 9'd91: r=8'h61; 9'd92: r=8'h51; 9'd93: r=8'h49; 9'd94: r=8'h46;
      9'd95: r=8'h21; 9'd96: r=8'h41; 9'd97: r=8'h45; 9'd98: r=8'h4B; 9'd99: r=8'h31;
      9'd100: r=8'h18; 9'd101: r=8'h14; 9'd102: r=8'h12; 9'd103: r=8'h7F; 9'd104: r=8'h10;
      9'd105: r=8'h27; 9'd106: r=8'h45; 9'd107: r=8'h45; 9'd108: r=8'h45; 9'd109: r=8'h39;
      9'd110: r=8'h3C; 9'd111: r=8'h4A; 9'd112: r=8'h49; 9'd113: r=8'h49; 9'd114: r=8'h30;
      9'd115: r=8'h01; 9'd116: r=8'h71; 9'd117: r=8'h09; 9'd118: r=8'h05; 9'd119: r=8'h03;
      9'd120: r=8'h36; 9'd121: r=8'h49; 9'd122: r=8'h49; 9'd123: r=8'h49; 9'd124: r=8'h36;
      9'd125: r=8'h06; 9'd126: r=8'h49; 9'd127: r=8'h49; 9'd128: r=8'h29; 9'd129: r=8'h1E;
      9'd131: r=8'h36; 9'd132: r=8'h36;
      9'd136: r=8'h56; 9'd137: r=8'h36;
      9'd140: r=8'h08; 9'd141: r=8'h14; 9'd142: r=8'h22; 9'd143: r=8'h41;
      9'd145: r=8'h14; 9'd146: r=8'h14; 9'd147: r=8'h14; 9'd148: r=8'h14; 9'd149: r=8'h14;
      9'd151: r=8'h41; 9'd152: r=8'h22; 9'd153: r=8'h14; 9'd154: r=8'h08;
      9'd155: r=8'h02; 9'd156: r=8'h01; 9'd157: r=8'h51; 9'd158: r=8'h09; 9'd159: r=8'h06;
      9'd160: r=8'h32; 9'd161: r=8'h49; 9'd162: r=8'h79; 9'd163: r=8'h41; 9'd164: r=8'h3E;
      9'd165: r=8'h7E; 9'd166: r=8'h11; 9'd167: r=8'h11; 9'd168: r=8'h11; 9'd169: r=8'h7E;
      9'd170: r=8'h7F; 9'd171: r=8'h49; 9'd172: r=8'h49; 9'd173: r=8'h49; 9'd174: r=8'h36;
      9'd175: r=8'h3E; 9'd176: r=8'h41; 9'd177: r=8'h41; 9'd178: r=8'h41; 9'd179: r=8'h22;
      9'd180: r=8'h7F; 9'd181: r=8'h41; 9'd182: r=8'h41; 9'd183: r=8'h22; 9'd184: r=8'h1C;
      9'd185: r=8'h7F; 9'd186: r=8'h49; 9'd187: r=8'h49; 9'd188: r=8'h49; 9'd189: r=8'h41;
      9'd190: r=8'h7F; 9'd191: r=8'h09; 9'd192: r=8'h09; 9'd193: r=8'h09; 9'd194: r=8'h01;
      9'd195: r=8'h3E; 9'd196: r=8'h41; 9'd197: r=8'h49; 9'd198: r=8'h49; 9'd199: r=8'h78;
      9'd200: r=8'h7F; 9'd201: r=8'h08; 9'd202: r=8'h08; 9'd203: r=8'h08; 9'd204: r=8'h7F;
      9'd206: r=8'h41; 9'd207: r=8'h7F; 9'd208: r=8'h41;
      9'd210: r=8'h20; 9'd211: r=8'h40; 9'd212: r=8'h41; 9'd213: r=8'h3F; 9'd214: r=8'h01;
      9'd215: r=8'h7F; 9'd216: r=8'h08; 9'd217: r=8'h14; 9'd218: r=8'h22; 9'd219: r=8'h41;
      9'd220: r=8'h7F; 9'd221: r=8'h40; 9'd222: r=8'h40; 9'd223: r=8'h40; 9'd224: r=8'h40;
      9'd225: r=8'h7F; 9'd226: r=8'h02; 9'd227: r=8'h0C; 9'd228: r=8'h02; 9'd229: r=8'h7F;
      9'd230: r=8'h7F; 9'd231: r=8'h04; 9'd232: r=8'h08; 9'd233: r=8'h10; 9'd234: r=8'h7F;
      9'd235: r=8'h3E; 9'd236: r=8'h41; 9'd237: r=8'h41; 9'd238: r=8'h41; 9'd239: r=8'h3E;
      9'd240: r=8'h7F; 9'd241: r=8'h09; 9'd242: r=8'h09; 9'd243: r=8'h09; 9'd244: r=8'h06;
      9'd245: r=8'h3E; 9'd246: r=8'h41; 9'd247: r=8'h51; 9'd248: r=8'h21; 9'd249: r=8'h5E;
      9'd250: r=8'h7F; 9'd251: r=8'h09; 9'd252: r=8'h19; 9'd253: r=8'h29; 9'd254: r=8'h46;
      9'd255: r=8'h46; 9'd256: r=8'h49; 9'd257: r=8'h49; 9'd258: r=8'h49; 9'd259: r=8'h31;
      9'd260: r=8'h01; 9'd261: r=8'h01; 9'd262: r=8'h7F; 9'd263: r=8'h01; 9'd264: r=8'h01;
      9'd265: r=8'h3F; 9'd266: r=8'h40; 9'd267: r=8'h40; 9'd268: r=8'h40; 9'd269: r=8'h3F;
      9'd270: r=8'h1F; 9'd271: r=8'h20; 9'd272: r=8'h40; 9'd273: r=8'h20; 9'd274: r=8'h1F;
      9'd275: r=8'h3F; 9'd276: r=8'h40; 9'd277: r=8'h38; 9'd278: r=8'h40; 9'd279: r=8'h3F;
      9'd280: r=8'h63; 9'd281: r=8'h14; 9'd282: r=8'h08; 9'd283: r=8'h14; 9'd284: r=8'h63;
      9'd285: r=8'h07; 9'd286: r=8'h08; 9'd287: r=8'h70; 9'd288: r=8'h08; 9'd289: r=8'h07;
      9'd290: r=8'h61; 9'd291: r=8'h51; 9'd292: r=8'h49; 9'd293: r=8'h45; 9'd294: r=8'h43;
      9'd296: r=8'h7F; 9'd297: r=8'h41; 9'd298: r=8'h41;
      9'd300: r=8'h02; 9'd301: r=8'h04; 9'd302: r=8'h08; 9'd303: r=8'h10; 9'd304: r=8'h20;
      9'd306: r=8'h41; 9'd307: r=8'h41; 9'd308: r=8'h7F;
      9'd310: r=8'h04; 9'd311: r=8'h02; 9'd312: r=8'h01; 9'd313: r=8'h02; 9'd314: r=8'h04;
      9'd315: r=8'h40; 9'd316: r=8'h40; 9'd317: r=8'h40; 9'd318: r=8'h40; 9'd319: r=8'h40;
      9'd321: r=8'h01; 9'd322: r=8'h02; 9'd323: r=8'h04;
      9'd325: r=8'h20; 9'd326: r=8'h54; 9'd327: r=8'h54; 9'd328: r=8'h54; 9'd329: r=8'h78;
      9'd331: r=8'h7F; 9'd332: r=8'h44; 9'd333: r=8'h44; 9'd334: r=8'h38;
      9'd335: r=8'h38; 9'd336: r=8'h44; 9'd337: r=8'h44; 9'd338: r=8'h44; 9'd339: r=8'h48;
      9'd341: r=8'h38; 9'd342: r=8'h44; 9'd343: r=8'h44; 9'd344: r=8'h7F;
      9'd345: r=8'h38; 9'd346: r=8'h54; 9'd347: r=8'h54; 9'd348: r=8'h54; 9'd349: r=8'h58;
      9'd351: r=8'h04; 9'd352: r=8'h7E; 9'd353: r=8'h05; 9'd354: r=8'h01;
      9'd355: r=8'h08; 9'd356: r=8'h54; 9'd357: r=8'h54; 9'd358: r=8'h54; 9'd359: r=8'h3C;
      9'd361: r=8'h7F; 9'd362: r=8'h04; 9'd363: r=8'h04; 9'd364: r=8'h78;
      9'd366: r=8'h44; 9'd367: r=8'h7D; 9'd368: r=8'h40;
      9'd370: r=8'h20; 9'd371: r=8'h40; 9'd372: r=8'h40; 9'd373: r=8'h3D;
      9'd376: r=8'h7F; 9'd377: r=8'h10; 9'd378: r=8'h28; 9'd379: r=8'h44;
      9'd381: r=8'h41; 9'd382: r=8'h7F; 9'd383: r=8'h40;
      9'd385: r=8'h7C; 9'd386: r=8'h04; 9'd387: r=8'h78; 9'd388: r=8'h04; 9'd389: r=8'h78;
      9'd391: r=8'h7C; 9'd392: r=8'h04; 9'd393: r=8'h04; 9'd394: r=8'h78;
      9'd395: r=8'h38; 9'd396: r=8'h44; 9'd397: r=8'h44; 9'd398: r=8'h44; 9'd399: r=8'h38;
      9'd400: r=8'h7C; 9'd401: r=8'h14; 9'd402: r=8'h14; 9'd403: r=8'h14; 9'd404: r=8'h08;
      9'd405: r=8'h08; 9'd406: r=8'h14; 9'd407: r=8'h14; 9'd408: r=8'h14; 9'd409: r=8'h7C;
      9'd411: r=8'h7C; 9'd412: r=8'h08; 9'd413: r=8'h04; 9'd414: r=8'h04;
      9'd415: r=8'h58; 9'd416: r=8'h54; 9'd417: r=8'h54; 9'd418: r=8'h54; 9'd419: r=8'h30;
      9'd421: r=8'h04; 9'd422: r=8'h3E; 9'd423: r=8'h44; 9'd424: r=8'h40;
      9'd426: r=8'h3C; 9'd427: r=8'h40; 9'd428: r=8'h40; 9'd429: r=8'h7C;
      9'd430: r=8'h1C; 9'd431: r=8'h20; 9'd432: r=8'h40; 9'd433: r=8'h20; 9'd434: r=8'h1C;
      9'd435: r=8'h3C; 9'd436: r=8'h40; 9'd437: r=8'h30; 9'd438: r=8'h40; 9'd439: r=8'h3C;
      9'd440: r=8'h44; 9'd441: r=8'h28; 9'd442: r=8'h10; 9'd443: r=8'h28; 9'd444: r=8'h44;
      9'd446: r=8'h0C; 9'd447: r=8'h50; 9'd448: r=8'h50; 9'd449: r=8'h3C;
      9'd450: r=8'h44; 9'd451: r=8'h64; 9'd452: r=8'h54; 9'd453: r=8'h4C; 9'd454: r=8'h44;
      9'd456: r=8'h08; 9'd457: r=8'h36; 9'd458: r=8'h41;
      9'd462: r=8'h7F;
      9'd466: r=8'h41; 9'd467: r=8'h36; 9'd468: r=8'h08;
      9'd470: r=8'h04; 9'd471: r=8'h02; 9'd472: r=8'h04; 9'd473: r=8'h08; 9'd474: r=8'h04;
      9'd475: r=8'h7F; 9'd476: r=8'h7F; 9'd477: r=8'h7F; 9'd478: r=8'h7F; 9'd479: r=8'h7F;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] glyph_hi(logic [8:0] i);
    logic [7:0] r;
    case (i)
      9'd5: r=8'h70; 9'd6: r=8'h50; 9'd7: r=8'h70;
      9'd12: r=8'h0F; 9'd13: r=8'h01; 9'd14: r=8'h01;
      9'd15: r=8'h40; 9'd16: r=8'h40; 9'd17: r=8'h78;
      9'd20: r=8'h10; 9'd21: r=8'h20; 9'd22: r=8'h40;
      9'd26: r=8'h0C; 9'd27: r=8'h0C;
      9'd30: r=8'h0A; 9'd31: r=8'h0A; 9'd32: r=8'h4A; 9'd33: r=8'h2A; 9'd34: r=8'h1E;
      9'd35: r=8'h04; 9'd36: r=8'h44; 9'd37: r=8'h34; 9'd38: r=8'h14; 9'd39: r=8'h0C;
      9'd40: r=8'h20; 9'd41: r=8'h10; 9'd42: r=8'h78; 9'd43: r=8'h04;
      9'd45: r=8'h18; 9'd46: r=8'h08; 9'd47: r=8'h4C; 9'd48: r=8'h48; 9'd49: r=8'h38;
      9'd50: r=8'h48; 9'd51: r=8'h48; 9'd52: r=8'h78; 9'd53: r=8'h48; 9'd54: r=8'h48;
      9'd55: r=8'h48; 9'd56: r=8'h28; 9'd57: r=8'h18; 9'd58: r=8'h7C; 9'd59: r=8'h08;
      9'd60: r=8'h08; 9'd61: r=8'h7C; 9'd62: r=8'h08; 9'd63: r=8'h28; 9'd64: r=8'h18;
      9'd65: r=8'h40; 9'd66: r=8'h48; 9'd67: r=8'h48; 9'd68: r=8'h78; 9'd69: r=8'h40;
      9'd70: r=8'h54; 9'd71: r=8'h54; 9'd72: r=8'h54; 9'd73: r=8'h7C;
      9'd75: r=8'h18; 9'd77: r=8'h58; 9'd78: r=8'h40; 9'd79: r=8'h38;
      9'd80: r=8'h08; 9'd81: r=8'h08; 9'd82: r=8'h08; 9'd83: r=8'h08; 9'd84: r=8'h08;
      9'd85: r=8'h01; 9'd86: r=8'h41; 9'd87: r=8'h3D; 9'd88: r=8'h09; 9'd89: r=8'h07;
      9'd90: r=8'h10; 9'd91: r=8'h08; 9'd92: r=8'h7C; 9'd93: r=8'h02; 9'd94: r=8'h01;
      9'd95: r=8'h0E; 9'd96: r=8'h02; 9'd97: r=8'h43; 9'd98: r=8'h22; 9'd99: r=8'h1E;
      9'd100: r=8'h42; 9'd101: r=8'h42; 9'd102: r=8'h7E; 9'd103: r=8'h42; 9'd104: r=8'h42;
      9'd105: r=8'h22; 9'd106: r=8'h12; 9'd107: r=8'h0A; 9'd108: r=8'h7F; 9'd109: r=8'h02;
      9'd110: r=8'h42; 9'd111: r=8'h3F; 9'd112: r=8'h02; 9'd113: r=8'h42; 9'd114: r=8'h3E;
      9'd115: r=8'h0A; 9'd116: r=8'h0A; 9'd117: r=8'h7F; 9'd118: r=8'h0A; 9'd119: r=8'h0A;
      9'd120: r=8'h08; 9'd121: r=8'h46; 9'd122: r=8'h42; 9'd123: r=8'h22; 9'd124: r=8'h1E;
      9'd125: r=8'h04; 9'd126: r=8'h03; 9'd127: r=8'h42; 9'd128: r=8'h3E; 9'd129: r=8'h02;
      9'd130: r=8'h42; 9'd131: r=8'h42; 9'd132: r=8'h42; 9'd133: r=8'h42; 9'd134: r=8'h7E;
      9'd135: r=8'h02; 9'd136: r=8'h4F; 9'd137: r=8'h22; 9'd138: r=8'h1F; 9'd139: r=8'h02;
      9'd140: r=8'h4A; 9'd141: r=8'h4A; 9'd142: r=8'h40; 9'd143: r=8'h20; 9'd144: r=8'h1C;
      9'd145: r=8'h42; 9'd146: r=8'h22; 9'd147: r=8'h12; 9'd148: r=8'h2A; 9'd149: r=8'h46;
      9'd150: r=8'h02; 9'd151: r=8'h3F; 9'd152: r=8'h42; 9'd153: r=8'h4A; 9'd154: r=8'h46;
      9'd155: r=8'h06; 9'd156: r=8'h48; 9'd157: r=8'h40; 9'd158: r=8'h20; 9'd159: r=8'h1E;
      9'd160: r=8'h08; 9'd161: r=8'h46; 9'd162: r=8'h4A; 9'd163: r=8'h32; 9'd164: r=8'h1E;
      9'd165: r=8'h0A; 9'd166: r=8'h4A; 9'd167: r=8'h3E; 9'd168: r=8'h09; 9'd169: r=8'h08;
      9'd170: r=8'h0E; 9'd172: r=8'h4E; 9'd173: r=8'h20; 9'd174: r=8'h1E;
      9'd175: r=8'h04; 9'd176: r=8'h45; 9'd177: r=8'h3D; 9'd178: r=8'h05; 9'd179: r=8'h04;
      9'd181: r=8'h7F; 9'd182: r=8'h08; 9'd183: r=8'h10;
      9'd185: r=8'h44; 9'd186: r=8'h24; 9'd187: r=8'h1F; 9'd188: r=8'h04; 9'd189: r=8'h04;
      9'd190: r=8'h40; 9'd191: r=8'h42; 9'd192: r=8'h42; 9'd193: r=8'h42; 9'd194: r=8'h40;
      9'd195: r=8'h42; 9'd196: r=8'h2A; 9'd197: r=8'h12; 9'd198: r=8'h2A; 9'd199: r=8'h06;
      9'd200: r=8'h22; 9'd201: r=8'h12; 9'd202: r=8'h7B; 9'd203: r=8'h16; 9'd204: r=8'h22;
      9'd206: r=8'h40; 9'd207: r=8'h20; 9'd208: r=8'h1F;
      9'd210: r=8'h78; 9'd212: r=8'h02; 9'd213: r=8'h04; 9'd214: r=8'h78;
      9'd215: r=8'h3F; 9'd216: r=8'h44; 9'd217: r=8'h44; 9'd218: r=8'h44; 9'd219: r=8'h44;
      9'd220: r=8'h02; 9'd221: r=8'h42; 9'd222: r=8'h42; 9'd223: r=8'h22; 9'd224: r=8'h1E;
      9'd225: r=8'h04; 9'd226: r=8'h02; 9'd227: r=8'h04; 9'd228: r=8'h08; 9'd229: r=8'h30;
      9'd230: r=8'h32; 9'd231: r=8'h02; 9'd232: r=8'h7F; 9'd233: r=8'h02; 9'd234: r=8'h32;
      9'd235: r=8'h02; 9'd236: r=8'h12; 9'd237: r=8'h22; 9'd238: r=8'h52; 9'd239: r=8'h0E;
      9'd240: r=8'h20; 9'd241: r=8'h2A; 9'd242: r=8'h2A; 9'd243: r=8'h2A; 9'd244: r=8'h40;
      9'd245: r=8'h38; 9'd246: r=8'h24; 9'd247: r=8'h22; 9'd248: r=8'h20; 9'd249: r=8'h70;
      9'd250: r=8'h40; 9'd251: r=8'h28; 9'd252: r=8'h10; 9'd253: r=8'h28; 9'd254: r=8'h06;
      9'd255: r=8'h0A; 9'd256: r=8'h3E; 9'd257: r=8'h4A; 9'd258: r=8'h4A; 9'd259: r=8'h4A;
      9'd260: r=8'h04; 9'd261: r=8'h7F; 9'd262: r=8'h04; 9'd263: r=8'h14; 9'd264: r=8'h0C;
      9'd265: r=8'h40; 9'd266: r=8'h42; 9'd267: r=8'h42; 9'd268: r=8'h7E; 9'd269: r=8'h40;
      9'd270: r=8'h4A; 9'd271: r=8'h4A; 9'd272: r=8'h4A; 9'd273: r=8'h4A; 9'd274: r=8'h7E;
      9'd275: r=8'h04; 9'd276: r=8'h05; 9'd277: r=8'h45; 9'd278: r=8'h25; 9'd279: r=8'h1C;
      9'd280: r=8'h0F; 9'd281: r=8'h40; 9'd282: r=8'h20; 9'd283: r=8'h1F;
      9'd285: r=8'h7E; 9'd287: r=8'h7E; 9'd288: r=8'h40; 9'd289: r=8'h30;
      9'd290: r=8'h7E; 9'd291: r=8'h40; 9'd292: r=8'h20; 9'd293: r=8'h10; 9'd294: r=8'h08;
      9'd295: r=8'h7E; 9'd296: r=8'h42; 9'd297: r=8'h42; 9'd298: r=8'h42; 9'd299: r=8'h7E;
      9'd300: r=8'h0E; 9'd301: r=8'h02; 9'd302: r=8'h42; 9'd303: r=8'h22; 9'd304: r=8'h1E;
      9'd305: r=8'h42; 9'd306: r=8'h42; 9'd307: r=8'h40; 9'd308: r=8'h20; 9'd309: r=8'h18;
      9'd310: r=8'h04; 9'd311: r=8'h08; 9'd312: r=8'h02; 9'd313: r=8'h04;
      9'd315: r=8'h07; 9'd316: r=8'h05; 9'd317: r=8'h07;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] glyph_col(logic [7:0] ch, logic [2:0] col);
    logic [7:0] r;
    logic [8:0] base;
    r = 8'h00;
    if (ch >= 8'h20 && ch < 8'h80) begin
      base = 9'(ch - 8'h20);
      r = glyph_lo(9'(base * 9'd5) + 9'(col));
    end else if (ch >= 8'hA0 && ch < 8'hE0) begin
      base = 9'(ch - 8'hA0);
      r = glyph_hi(9'(base * 9'd5) + 9'(col));
    end
    return r;
  endfunction

endpackage

FILE: design/lcdc_ctrl.sv
// control state machine for the lcd controller
// sequences clear pass, request execution, memory read, character columns and result
// depends on lcdc_pkg
module lcdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lcdc_pkg::lcdc_sts_t sts_i,
  output lcdc_pkg::lcdc_cmd_t cmd_o
);
  import lcdc_pkg::*;

  lcdc_state_e state_q, state_d;
  logic [2:0]  col_q, col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      col_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
    end
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    case (state_q)
      StClear: if (sts_i.clr_last) state_d = StIdle;
      StIdle: begin
        if (in_valid) state_d = StExec;
      end
      StExec: begin
        if (sts_i.is_char) begin
          state_d = StChar;
          col_d   = 3'd4;
        end else if (sts_i.is_read) state_d = StRead;
        else state_d = StOut;
      end
      StChar: begin
        if (col_q == 3'd0) state_d = StOut;
        else col_d = col_q - 3'd1;
      end
      StRead: state_d = StOut;
      StOut: if (!out_stall) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = OpNone;
    cmd_o.col      = col_q;
    in_stall       = (state_q != StIdle);
    out_valid      = (state_q == StOut);
    case (state_q)
      StClear: cmd_o.clr = 1'b1;
      StIdle:  cmd_o.load_req = in_valid;
      StExec:  cmd_o.op = OpExec;
      StChar:  cmd_o.op = OpChar;
      StRead:  cmd_o.op = OpRead;
      default: cmd_o.op = OpNone;
    endcase
    cmd_o.load_out = (state_q == StExec && !sts_i.is_char && !sts_i.is_read) ||
                     (state_q == StChar && col_q == 3'd0) || (state_q == StRead);
  end

endmodule

FILE: design/lcdc_dpath.sv
// datapath for the lcd controller: display memory, pointer, mode, result
// executes commands from lcdc_ctrl
// depends on lcdc_pkg
module lcdc_dpath #(
  parameter int unsigned MemDepth = lcdc_pkg::MemDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcdc_pkg::lcdc_req_t req_i,
  input  lcdc_pkg::lcdc_cmd_t cmd_i,
  output lcdc_pkg::lcdc_sts_t sts_o,
  output lcdc_pkg::lcdc_rsp_t rsp_o
);
  import lcdc_pkg::*;

  localparam int unsigned AW = $clog2(MemDepth);

  logic [7:0]    mem_q [MemDepth];
  logic [7:0]    rd_q;
  lcdc_req_t     req_q;
  logic [6:0]    ptr_q, ptr_d;
  logic [7:0]    mode_q, mode_d;
  lcdc_rsp_t     rsp_q;
  logic [AW-1:0] clr_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] paddr;
  logic [7:0]    mask;
  logic          is_instr, is_data;

  // a 7-bit address is below twice the smallest depth, one subtract wraps it
  function automatic logic [AW-1:0] to_addr(logic [6:0] a);
    logic [8:0] w;
    w = {2'b00, a};
    if (w >= 9'(MemDepth)) w = w - 9'(MemDepth);
    return w[AW-1:0];
  endfunction

  assign paddr    = to_addr(ptr_q);
  assign is_instr = (req_q.action == ActInstr);
  assign is_data  = (req_q.action == ActData);
  assign mask     = 8'(8'd1 << req_q.value[4:2]);

  assign sts_o.is_char  = is_data && (mode_q == ModeRight || mode_q == ModeLeft);
  assign sts_o.is_read  = (req_q.action == ActRead) || (is_instr && !req_q.value[7] &&
                          req_q.value[6] != req_q.value[5]);
  assign sts_o.clr_last = (32'(clr_q) == MemDepth - 1);

  always_comb begin
    ptr_d  = ptr_q;
    mode_d = mode_q;
    we     = 1'b0;
    waddr  = paddr;
    wdata  = 8'h00;
    if (cmd_i.clr) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (cmd_i.op == OpExec) begin
      if (is_instr) begin
        if (req_q.value[7]) begin
          ptr_d = req_q.value[6:0];
          if (mode_q >= 8'h60 && mode_q <= 8'h63) ptr_d = step_ptr(req_q.value[6:0], mode_q[1:0]);
        end else if (req_q.value[6:5] == 2'b11) begin
          mode_d = req_q.value;
          if (req_q.value <= 8'h63) ptr_d = step_ptr(ptr_q, req_q.value[1:0]);
        end
      end else if (is_data && mode_q >= 8'h64 && mode_q <= 8'h67) begin
        we    = 1'b1;
        wdata = req_q.value;
        ptr_d = step_ptr(ptr_q, mode_q[1:0]);
      end
    end else if (cmd_i.op == OpChar) begin
      we    = 1'b1;
      wdata = glyph_col(req_q.value, cmd_i.col);
      ptr_d = (mode_q == ModeRight) ? 7'(ptr_q + 7'd1) : 7'(ptr_q - 7'd1);
    end else if (cmd_i.op == OpRead && is_instr) begin
      we    = 1'b1;
      wdata = req_q.value[6] ? (rd_q | mask) : (rd_q & ~mask);
      ptr_d = step_ptr(ptr_q, req_q.value[1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[(req_q.action == ActRead) ? to_addr(req_q.read_address) : paddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= 7'd0;
      mode_q <= ModeReset;
      clr_q  <= '0;
    end else begin
      ptr_q  <= ptr_d;
      mode_q <= mode_d;
      if (cmd_i.clr) clr_q <= AW'(clr_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.load_out) begin
      rsp_q.read_data   <= (cmd_i.op == OpRead && !is_instr) ? rd_q : 8'h00;
      rsp_q.pointer_now <= ptr_d;
      rsp_q.mode_now    <= mode_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

FILE: design/lcd_controller_display_memory.sv
// Segment LCD controller with a MemDepth-byte display memory, data pointer,
// mode byte and built-in 5x7 font. After reset a clearing pass zeroes the
// whole memory while in_stall stays high. Then an item goes from StIdle
// through StExec to StOut (through StRead too for a read or a bit set/reset,
// which read the memory first; through StChar for a character entry, one
// column written per cycle through the single memory write port); one item
// is worked at a time and the next is taken once the result has been taken.
module lcd_controller_display_memory #(
  parameter int unsigned MemDepth = lcdc_pkg::MemDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcdc_pkg::lcdc_req_t in_data_i,
  output logic                out_valid,
  input  logic                out_stall,
  output lcdc_pkg::lcdc_rsp_t out_data_o
);
  import lcdc_pkg::*;

  lcdc_cmd_t cmd;
  lcdc_sts_t sts;

  lcdc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid,
    .in_stall,
    .out_valid,
    .out_stall,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  lcdc_dpath #(.MemDepth(MemDepth)) u_dpath (
    .clk_i,
    .rst_ni,
    .req_i (in_data_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (out_data_o)
  );

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data_o)) else $error("out hold");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("in taken while result pending");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> in_stall && !out_valid) else $error("accept seq");
`endif

endmodule
